// File: rtl/cpi_pkg.sv
// Package for the complex polyphase interpolator core.
// Shared widths, tap register layout and the pipeline control struct.
// No dependencies.
package cpi_pkg;

    localparam int INTERP_FACTOR_DEF  = 4;
    localparam int TAPS_PER_PHASE_DEF = 8;

    localparam int SAMPLE_W      = 16;
    localparam int TAP_W         = 16;
    localparam int PROD_W        = SAMPLE_W + TAP_W;
    localparam int FRAC_BITS     = 12;   // taps are Q4.12
    localparam int PHASE_OUT_W   = 2;

    localparam int TAPS_PER_REG  = 4;
    localparam int TAP_REG_COUNT = 8;
    localparam int TAP_COUNT     = TAP_REG_COUNT * TAPS_PER_REG;
    localparam int TAP_REG_IDX_W = $clog2(TAP_REG_COUNT);
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = TAPS_PER_REG * TAP_W;

    // Load strobes for the dot-product pipeline
    typedef struct packed {
        logic prod_load;  // capture products for the phase being issued
        logic sum_load;   // capture the summed products
    } cpi_pipe_ctl_t;

endpackage

// File: rtl/cpi_dot_pipe.sv
// Two-stage complex dot product: registered products, then registered sum.
// Depends on cpi_pkg.
module cpi_dot_pipe
    import cpi_pkg::*;
#(
    parameter int TAPS_PER_PHASE = TAPS_PER_PHASE_DEF,
    parameter int ACC_W          = PROD_W + $clog2(TAPS_PER_PHASE + 1)
)
(
    input  logic                clk,
    input  cpi_pipe_ctl_t       ctl,
    input  logic [SAMPLE_W-1:0] hist_i [TAPS_PER_PHASE],
    input  logic [SAMPLE_W-1:0] hist_q [TAPS_PER_PHASE],
    input  logic [TAP_W-1:0]    taps   [TAPS_PER_PHASE],
    output logic [ACC_W-1:0]    sum_i,
    output logic [ACC_W-1:0]    sum_q
);

    logic signed [PROD_W-1:0] prod_i_reg [TAPS_PER_PHASE];
    logic signed [PROD_W-1:0] prod_q_reg [TAPS_PER_PHASE];
    logic signed [ACC_W-1:0]  sum_i_next;
    logic signed [ACC_W-1:0]  sum_q_next;
    logic signed [ACC_W-1:0]  sum_i_reg;
    logic signed [ACC_W-1:0]  sum_q_reg;

    // one 16x16 multiply per lane and rail
    always_ff @(posedge clk)
    begin
        if (ctl.prod_load)
        begin
            for (int n = 0; n < TAPS_PER_PHASE; n++)
            begin
                prod_i_reg[n] <= $signed(taps[n]) * $signed(hist_i[n]);
                prod_q_reg[n] <= $signed(taps[n]) * $signed(hist_q[n]);
            end
        end
    end

    always_comb
    begin
        sum_i_next = '0;
        sum_q_next = '0;
        for (int n = 0; n < TAPS_PER_PHASE; n++)
        begin
            sum_i_next = sum_i_next + ACC_W'(prod_i_reg[n]);
            sum_q_next = sum_q_next + ACC_W'(prod_q_reg[n]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_load)
        begin
            sum_i_reg <= sum_i_next;
            sum_q_reg <= sum_q_next;
        end
    end

    assign sum_i = sum_i_reg;
    assign sum_q = sum_q_reg;

endmodule

// File: rtl/complex_polyphase_interpolator_core.sv
// Top level of the complex polyphase FIR interpolator.
// Depends on cpi_pkg and cpi_dot_pipe.

// Each accepted complex int16 sample is pushed into a TAPS_PER_PHASE deep
// delay line (zero after reset) and produces INTERP_FACTOR results, one per
// polyphase branch in order 0..INTERP_FACTOR-1, with tlast on the final
// branch and the branch number (modulo 4) on tuser. Taps are 32 signed
// Q4.12 values loaded four at a time through the config port (index 0
// holds taps 0..3, lowest tap in the low bits; indexes 8 and up are
// dropped); taps past 31 read as zero. Each sum is rounded half to even
// and wrapped to 16 bits. One result per cycle while the output is not
// stalled; the single shared multiply/sum path evaluates one branch at a
// time. From branch issue a result passes the product register, the sum
// register and then the result register. A new sample is taken
// while the previous one issues its last branch, so the pipeline does not
// drain between back-to-back items; waiting results at the output do not
// block input until the pipeline stages behind them are full. Taps may
// only be rewritten while the core is idle.
module complex_polyphase_interpolator_core
    import cpi_pkg::*;
#(
    parameter int INTERP_FACTOR  = INTERP_FACTOR_DEF,
    parameter int TAPS_PER_PHASE = TAPS_PER_PHASE_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [15:0] sample_i, [31:16] sample_q

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // [15:0] out_i, [31:16] out_q
    output logic [PHASE_OUT_W-1:0] m_axis_tuser,   // [1:0] phase_index
    output logic                   m_axis_tlast,   // last

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PHASE_W   = $clog2(INTERP_FACTOR);
    localparam int ACC_W     = PROD_W + $clog2(TAPS_PER_PHASE + 1);
    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(INTERP_FACTOR - 1);

    // ---------------- tap registers ----------------
    logic [CFG_DATA_W-1:0] tap_reg [TAP_REG_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < TAP_REG_COUNT; r++)
                tap_reg[r] <= '0;
        end
        else if (cfg_valid && (32'(cfg_index) < TAP_REG_COUNT))
        begin
            tap_reg[cfg_index[TAP_REG_IDX_W-1:0]] <= cfg_data;
        end
    end

    // ---------------- sample history ----------------
    logic [SAMPLE_W-1:0] hist_i_reg [TAPS_PER_PHASE];
    logic [SAMPLE_W-1:0] hist_q_reg [TAPS_PER_PHASE];
    logic                in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < TAPS_PER_PHASE; n++)
            begin
                hist_i_reg[n] <= '0;
                hist_q_reg[n] <= '0;
            end
        end
        else if (in_accept)
        begin
            hist_i_reg[0] <= s_axis_tdata[15:0];
            hist_q_reg[0] <= s_axis_tdata[31:16];
            for (int n = 1; n < TAPS_PER_PHASE; n++)
            begin
                hist_i_reg[n] <= hist_i_reg[n-1];
                hist_q_reg[n] <= hist_q_reg[n-1];
            end
        end
    end

    // ---------------- elastic pipeline control ----------------
    logic               busy_reg, busy_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               s1_v_reg, s1_v_next;
    logic               s2_v_reg, s2_v_next;
    logic               out_v_reg, out_v_next;
    logic               out_ok, s2_ok, s1_ok;
    logic               issue, last_issue;
    cpi_pipe_ctl_t      pipe_ctl;

    assign out_ok     = !out_v_reg || m_axis_tready;
    assign s2_ok      = !s2_v_reg || out_ok;
    assign s1_ok      = !s1_v_reg || s2_ok;
    assign issue      = busy_reg && s1_ok;
    assign last_issue = issue && (phase_reg == LAST_PHASE);

    // the delay line is the operand snapshot, so the next sample enters
    // only as the current one issues its final branch
    assign s_axis_tready = !busy_reg || last_issue;

    assign pipe_ctl.prod_load = issue;
    assign pipe_ctl.sum_load  = s1_v_reg && s2_ok;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (in_accept)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
        end
        else if (last_issue)
        begin
            busy_next = 1'b0;
        end
        else if (issue)
        begin
            phase_next = phase_reg + 1'b1;
        end

        s1_v_next  = issue ? 1'b1 : (s2_ok ? 1'b0 : s1_v_reg);
        s2_v_next  = s2_ok ? s1_v_reg : s2_v_reg;
        out_v_next = out_ok ? s2_v_reg : out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // ---------------- per-lane tap select ----------------
    // lane n sees taps INTERP_FACTOR*n + p; the candidates are fixed wiring
    logic [TAP_W-1:0] tap_cand [TAPS_PER_PHASE][INTERP_FACTOR];
    logic [TAP_W-1:0] lane_tap [TAPS_PER_PHASE];

    for (genvar n = 0; n < TAPS_PER_PHASE; n++)
    begin : g_lane
        for (genvar j = 0; j < INTERP_FACTOR; j++)
        begin : g_cand
            localparam int K = INTERP_FACTOR * n + j;
            if (K < TAP_COUNT)
            begin : g_real
                assign tap_cand[n][j] =
                    tap_reg[K / TAPS_PER_REG][(K % TAPS_PER_REG) * TAP_W +: TAP_W];
            end
            else
            begin : g_zero
                assign tap_cand[n][j] = '0;
            end
        end
        assign lane_tap[n] = tap_cand[n][phase_reg];
    end

    // ---------------- dot product ----------------
    logic [ACC_W-1:0] sum_i, sum_q;

    cpi_dot_pipe #(
        .TAPS_PER_PHASE (TAPS_PER_PHASE),
        .ACC_W          (ACC_W)
    ) u_dot (
        .clk    (clk),
        .ctl    (pipe_ctl),
        .hist_i (hist_i_reg),
        .hist_q (hist_q_reg),
        .taps   (lane_tap),
        .sum_i  (sum_i),
        .sum_q  (sum_q)
    );

    // branch number rides alongside the data
    logic [PHASE_W-1:0] s1_phase_reg, s2_phase_reg, out_phase_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_ctl.prod_load)
            s1_phase_reg <= phase_reg;
        if (pipe_ctl.sum_load)
            s2_phase_reg <= s1_phase_reg;
    end

    // ---------------- round half to even, wrap to 16 bits ----------------
    logic                inc_i, inc_q;
    logic [SAMPLE_W-1:0] out_i_next, out_q_next;
    logic [SAMPLE_W-1:0] out_i_reg, out_q_reg;
    logic                out_load;

    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    always_comb
    begin
        inc_i = (sum_i[FRAC_BITS-1:0] > HALF) ||
                ((sum_i[FRAC_BITS-1:0] == HALF) && sum_i[FRAC_BITS]);
        inc_q = (sum_q[FRAC_BITS-1:0] > HALF) ||
                ((sum_q[FRAC_BITS-1:0] == HALF) && sum_q[FRAC_BITS]);
        out_i_next = sum_i[FRAC_BITS +: SAMPLE_W] + SAMPLE_W'(inc_i);
        out_q_next = sum_q[FRAC_BITS +: SAMPLE_W] + SAMPLE_W'(inc_q);
    end

    assign out_load = s2_v_reg && out_ok;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_i_reg     <= out_i_next;
            out_q_reg     <= out_q_next;
            out_phase_reg <= s2_phase_reg;
        end
    end

    logic [31:0] out_phase_ext;
    assign out_phase_ext = 32'(out_phase_reg);

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_q_reg, out_i_reg};
    assign m_axis_tuser  = out_phase_ext[PHASE_OUT_W-1:0];
    assign m_axis_tlast  = (out_phase_reg == LAST_PHASE);

    // ---------------- assertions ----------------
    // a sample may only enter between items or on the final branch issue
    a_accept_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && busy_reg) |-> last_issue)
        else $error("sample accepted mid-item");

    // every issued branch lands in the product stage
    a_issue_fills: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> s1_v_reg)
        else $error("issued branch lost");

    // an accepted sample always starts at branch zero
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (busy_reg && (phase_reg == '0)))
        else $error("item did not start at branch zero");

    // a stalled result must not be overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule
